// ===== src/lapedge_pkg.sv =====
// shared types, constants and arithmetic for the laplacian rgb edge filter
// used by lapedge_pos, lapedge_emit and the top level; no dependencies

package lapedge_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WCNT_W      = COL_W + 1;
    localparam int ROW_W       = 12;
    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int LINE_W      = 2 * PIX_W;
    localparam int IN_DATA_W   = PIX_W;
    localparam int RES_W       = PIX_W + COL_W + ROW_W;
    localparam int OUT_DATA_W  = ((RES_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int CFG_DATA_W   = 12;

    localparam logic [CFG_INDEX_W-1:0]  REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0]  REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd800;
    localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd600;

    // one bit per result an input can cause, in delivery order
    localparam logic [2:0] EMIT_UPPER_ROW  = 3'b001;
    localparam logic [2:0] EMIT_LEFT_PIXEL = 3'b010;
    localparam logic [2:0] EMIT_ROW_END    = 3'b100;

    // red in bits 7..0, green in 15..8, blue in 23..16
    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             row_ge1;
        logic             row_ge2;
        logic             col_ge1;
        logic             col_ge2;
        logic             right_ok;
        logic [2:0]       emit_mask;
    } pos_t;

    typedef struct packed {
        pixel_t           pix;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             eof;
    } res_t;

    typedef struct packed {
        logic              rd_en;
        logic [COL_W-1:0]  rd_addr_a;
        logic [COL_W-1:0]  rd_addr_b;
        logic              wr_en;
        logic [COL_W-1:0]  wr_addr;
        logic [LINE_W-1:0] wr_data;
    } ram_req_t;

    function automatic logic [CH_W-1:0] lap_chan(
        input logic [CH_W-1:0] up,
        input logic [CH_W-1:0] dn,
        input logic [CH_W-1:0] lf,
        input logic [CH_W-1:0] rt,
        input logic [CH_W-1:0] ce
    );
        logic [CH_W+1:0]        sum;
        logic signed [CH_W+2:0] diff;
        sum  = (CH_W+2)'(up) + (CH_W+2)'(dn) + (CH_W+2)'(lf) + (CH_W+2)'(rt);
        diff = $signed({1'b0, sum}) - $signed({1'b0, ce, 2'b00});
        if (diff < 0)
            return '0;
        else if (diff > $signed((CH_W+3)'(255)))
            return '1;
        else
            return diff[CH_W-1:0];
    endfunction

    function automatic pixel_t lap_pix(
        input pixel_t up,
        input pixel_t dn,
        input pixel_t lf,
        input pixel_t rt,
        input pixel_t ce
    );
        pixel_t res;
        for (int i = 0; i < 3; i++)
        begin
            res[i*CH_W +: CH_W] = lap_chan(up[i*CH_W +: CH_W], dn[i*CH_W +: CH_W],
                                           lf[i*CH_W +: CH_W], rt[i*CH_W +: CH_W],
                                           ce[i*CH_W +: CH_W]);
        end
        return res;
    endfunction

endpackage

// ===== src/lapedge_ram.sv =====
// generic ram: one write port, two registered read ports, read-first
// no package dependencies

module lapedge_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_a_reg;
    logic [WIDTH-1:0] rd_data_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= mem_reg[rd_addr_a];
            rd_data_b_reg <= mem_reg[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

// ===== src/lapedge_pos.sv =====
// frame size registers, position counters and per-pixel position flags
// depends on lapedge_pkg

module lapedge_pos
    import lapedge_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   accept,
    input  logic                   sof,
    output pos_t                   pos_now,
    output pos_t                   pos_q
);

    logic [CFG_WIDTH_W-1:0]  frame_width_reg;
    logic [CFG_HEIGHT_W-1:0] frame_height_reg;
    logic [COL_W-1:0]        col_count_reg;
    logic [COL_W-1:0]        col_count_next;
    logic [ROW_W-1:0]        row_count_reg;
    logic [ROW_W-1:0]        row_count_next;
    pos_t                    pos_q_reg;

    logic [WCNT_W-1:0] width_eff;
    logic [ROW_W-1:0]  height_eff;
    logic [COL_W-1:0]  col_start;
    logic [ROW_W-1:0]  row_start;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic [WCNT_W-1:0] col_inc;
    logic [ROW_W-1:0]  row_inc;
    logic              last_row;
    logic              last_col;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = WCNT_W'(1);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            width_eff = WCNT_W'(MAX_WIDTH);
        else
            width_eff = WCNT_W'(frame_width_reg);

        height_eff = (frame_height_reg == '0) ? ROW_W'(1) : frame_height_reg;

        // position of this pixel
        col_start = sof ? '0 : col_count_reg;
        row_start = sof ? '0 : row_count_reg;
        if ({1'b0, col_start} >= width_eff)
        begin
            col_cur = '0;
            row_cur = row_start + ROW_W'(1);
        end
        else
        begin
            col_cur = col_start;
            row_cur = row_start;
        end
        if (row_cur >= height_eff)
        begin
            row_cur = '0;
        end

        last_row = (row_cur == height_eff - ROW_W'(1));
        last_col = ({1'b0, col_cur} == width_eff - WCNT_W'(1));

        pos_now.col      = col_cur;
        pos_now.row      = row_cur;
        pos_now.row_ge1  = (row_cur != '0);
        pos_now.row_ge2  = (row_cur >= ROW_W'(2));
        pos_now.col_ge1  = (col_cur != '0);
        pos_now.col_ge2  = (col_cur >= COL_W'(2));
        pos_now.right_ok = ({1'b0, col_cur} + WCNT_W'(1)) < width_eff;
        pos_now.emit_mask = (pos_now.row_ge1 ? EMIT_UPPER_ROW : '0)
                          | ((last_row && pos_now.col_ge1) ? EMIT_LEFT_PIXEL : '0)
                          | ((last_row && last_col) ? EMIT_ROW_END : '0);

        // position of the next pixel
        col_inc = {1'b0, col_cur} + WCNT_W'(1);
        if (col_inc >= width_eff)
        begin
            col_count_next = '0;
            row_inc = row_cur + ROW_W'(1);
            row_count_next = (row_inc >= height_eff) ? '0 : row_inc;
        end
        else
        begin
            row_inc = row_cur;
            col_count_next = col_inc[COL_W-1:0];
            row_count_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_q_reg <= pos_now;
        end
    end

    assign pos_q = pos_q_reg;

`ifndef ASSERT_OFF
    a_sof_origin: assert property (@(posedge clk) disable iff (!rst_n)
        accept && sof |=> pos_q_reg.col == '0 && pos_q_reg.row == '0)
        else $error("start of frame did not put the pixel at the origin");

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg != '1)
        else $error("row counter reached an impossible value");
`endif

endmodule

// ===== src/lapedge_emit.sv =====
// stage with the pixel in flight, line store forwarding, laplacian and result register
// depends on lapedge_pkg

module lapedge_emit
    import lapedge_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pixel_t            in_pixel,
    input  pos_t              pos_now,
    input  pos_t              pos_q,
    output ram_req_t          ram_req,
    input  logic [LINE_W-1:0] ram_rd_a,
    input  logic [LINE_W-1:0] ram_rd_b,
    output logic              out_valid,
    input  logic              out_ready,
    output res_t              out_res
);

    logic              s1_valid_reg;
    logic [2:0]        pend_reg;
    pixel_t            px_reg;
    logic              fwd_a_reg;
    logic              fwd_b_reg;
    logic [LINE_W-1:0] fwd_a_val_reg;
    pixel_t            fwd_b_val_reg;
    pixel_t            hml_reg;
    pixel_t            prev_reg;
    pixel_t            prev2_reg;
    logic              out_valid_reg;
    res_t              out_res_reg;

    logic [LINE_W-1:0] line_a;
    pixel_t            up_raw;
    pixel_t            mid;
    pixel_t            rt_raw;
    logic [2:0]        pend_low;
    logic [2:0]        pend_rest;
    logic              out_load;
    logic              take;
    logic              s1_leave;
    logic              accept;
    pixel_t            op_up;
    pixel_t            op_dn;
    pixel_t            op_lf;
    pixel_t            op_rt;
    pixel_t            op_ce;
    res_t              res;

    assign line_a = fwd_a_reg ? fwd_a_val_reg : ram_rd_a;
    assign up_raw = line_a[LINE_W-1:PIX_W];
    assign mid    = line_a[PIX_W-1:0];
    assign rt_raw = fwd_b_reg ? fwd_b_val_reg : ram_rd_b[PIX_W-1:0];

    assign pend_low  = pend_reg & (~pend_reg + 3'd1);
    assign pend_rest = pend_reg & ~pend_low;
    assign out_load  = !out_valid_reg || out_ready;
    assign take      = s1_valid_reg && (pend_reg != '0) && out_load;
    assign s1_leave  = s1_valid_reg && ((pend_reg == '0) || (take && pend_rest == '0));
    assign in_ready  = !s1_valid_reg || s1_leave;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        op_up   = '0;
        op_dn   = '0;
        op_lf   = '0;
        op_rt   = '0;
        op_ce   = '0;
        res.col = pos_q.col;
        res.row = pos_q.row;
        res.eof = 1'b0;
        case (pend_low)
            EMIT_UPPER_ROW:
            begin
                op_up   = pos_q.row_ge2 ? up_raw : '0;
                op_dn   = px_reg;
                op_lf   = pos_q.col_ge1 ? hml_reg : '0;
                op_rt   = pos_q.right_ok ? rt_raw : '0;
                op_ce   = mid;
                res.row = pos_q.row - ROW_W'(1);
            end
            EMIT_LEFT_PIXEL:
            begin
                op_up   = pos_q.row_ge1 ? hml_reg : '0;
                op_lf   = pos_q.col_ge2 ? prev2_reg : '0;
                op_rt   = px_reg;
                op_ce   = prev_reg;
                res.col = pos_q.col - COL_W'(1);
            end
            EMIT_ROW_END:
            begin
                op_up   = pos_q.row_ge1 ? mid : '0;
                op_lf   = pos_q.col_ge1 ? prev_reg : '0;
                op_ce   = px_reg;
                res.eof = 1'b1;
            end
            default: ;
        endcase
        res.pix  = lap_pix(op_up, op_dn, op_lf, op_rt, op_ce);
        res.last = (pend_rest == '0);
    end

    // a pixel leaving the stage writes its column, in the same cycle as the next read if a pixel is accepted then
    always_comb
    begin
        ram_req.rd_en     = accept;
        ram_req.rd_addr_a = pos_now.col;
        ram_req.rd_addr_b = pos_now.col + COL_W'(1);
        ram_req.wr_en     = s1_leave;
        ram_req.wr_addr   = pos_q.col;
        ram_req.wr_data   = {mid, px_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pend_reg      <= '0;
            fwd_a_reg     <= 1'b0;
            fwd_b_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                pend_reg     <= pos_now.emit_mask;
                fwd_a_reg    <= s1_leave && (pos_now.col == pos_q.col);
                fwd_b_reg    <= s1_leave &&
                                (({1'b0, pos_now.col} + WCNT_W'(1)) == {1'b0, pos_q.col});
            end
            else
            begin
                if (s1_leave)
                begin
                    s1_valid_reg <= 1'b0;
                end
                if (take)
                begin
                    pend_reg <= pend_rest;
                end
            end

            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg        <= in_pixel;
            fwd_a_val_reg <= {mid, px_reg};
            fwd_b_val_reg <= px_reg;
        end
        if (s1_leave)
        begin
            hml_reg   <= mid;
            prev2_reg <= prev_reg;
            prev_reg  <= px_reg;
        end
        if (take)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

`ifndef ASSERT_OFF
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> pend_reg == '0)
        else $error("results pending with no pixel in the stage");

    a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.eof |-> out_res_reg.last)
        else $error("frame end result not marked last of its run");

    a_empty_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && pend_reg == '0 |-> in_ready)
        else $error("pixel without results blocked the input");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("result taken from the stage was not registered");
`endif

endmodule

// ===== src/laplacian_edge_filter_rgb_unit.sv =====
// top level of the 4-neighbor laplacian rgb edge filter
// depends on lapedge_pkg, lapedge_ram, lapedge_pos, lapedge_emit
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  s        in         s_tvalid/s_tready    s_tdata pixel, s_tuser start of frame
//  m        out        m_tvalid/m_tready    m_tdata result, m_tlast, m_tuser
//
// a taken pixel is registered in the stage, then its first result in the output
// register; one pixel per cycle while m_tready is high and each pixel gives at
// most one result; on the frame's last row a pixel gives up to three results,
// one per cycle through the output register while m_tready is high; input waits for them
// reset clears counters and handshake state and sets the frame size to 800x600; the line stores are not cleared
// m_tready low holds the output register and, once the stage is full, s_tready

module laplacian_edge_filter_rgb_unit
    import lapedge_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // in_red, in_green, in_blue
    input  logic                   s_tuser,   // start_of_frame
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // out_red, out_green, out_blue, out_col, out_row
    output logic                   m_tlast,   // last_of_run
    output logic                   m_tuser    // end_of_frame
);

    pos_t              pos_now;
    pos_t              pos_q;
    ram_req_t          ram_req;
    logic [LINE_W-1:0] ram_rd_a;
    logic [LINE_W-1:0] ram_rd_b;
    res_t              out_res;
    logic              accept;

    assign accept = s_tvalid && s_tready;

    lapedge_pos u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .sof       (s_tuser),
        .pos_now   (pos_now),
        .pos_q     (pos_q)
    );

    // upper line in the high half, middle line in the low half
    lapedge_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk       (clk),
        .wr_en     (ram_req.wr_en),
        .wr_addr   (ram_req.wr_addr),
        .wr_data   (ram_req.wr_data),
        .rd_en     (ram_req.rd_en),
        .rd_addr_a (ram_req.rd_addr_a),
        .rd_addr_b (ram_req.rd_addr_b),
        .rd_data_a (ram_rd_a),
        .rd_data_b (ram_rd_b)
    );

    lapedge_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata),
        .pos_now   (pos_now),
        .pos_q     (pos_q),
        .ram_req   (ram_req),
        .ram_rd_a  (ram_rd_a),
        .ram_rd_b  (ram_rd_b),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = OUT_DATA_W'({out_res.row, out_res.col, out_res.pix});
    assign m_tlast = out_res.last;
    assign m_tuser = out_res.eof;

endmodule
